// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the frame parser RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define AFRP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define AFRP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define AFRP_ASSERT(lbl, clk, rst_n, prop, msg)
`define AFRP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/afrp_pkg.sv =====
// Shared types and constants of the ASCII frame receiver/parser.
// No dependencies; used by every module of the block but afrp_ram.
`timescale 1ns / 1ps
package afrp_pkg;

  // Longest frame, head byte included
  localparam int BUF_LEN = 32;
  localparam int CNT_W   = $clog2(BUF_LEN + 1);
  localparam int ADDR_W  = $clog2(BUF_LEN);
  // Two message banks, one per queued frame
  localparam int RAM_AW    = ADDR_W + 1;
  localparam int RAM_DEPTH = 2 * (1 << ADDR_W);

  localparam logic [7:0] HEAD_RST  = 8'd36;
  localparam logic [7:0] TAIL_RST  = 8'd35;
  localparam logic [7:0] FUNC_RST  = 8'd12;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [1:0] REG_HEAD = 2'd0;
  localparam logic [1:0] REG_TAIL = 2'd1;
  localparam logic [1:0] REG_FUNC = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_LEN_ERR = 2'd1,
    STAT_ID_ERR  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] head_byte;
    logic [7:0] tail_byte;
    logic [7:0] function_id;
  } cfg_t;

  // One finished frame handed from front to back
  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] len;
    logic             bank;
  } desc_t;

endpackage

// ===== rtl/afrp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module afrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/afrp_front.sv =====
// Front end: frame detection, field parsing and message capture.
// Depends on afrp_pkg; writes message bytes into the bank RAM.
`timescale 1ns / 1ps
module afrp_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  afrp_pkg::cfg_t            cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                rx_byte_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output afrp_pkg::desc_t           desc_o,
  output logic                      ram_we_o,
  output logic [afrp_pkg::RAM_AW-1:0] ram_waddr_o,
  output logic [7:0]                ram_wdata_o
);
  import afrp_pkg::*;

  localparam logic [1:0] PH_SKIP  = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  logic             in_frame_q, in_frame_d;
  logic             bank_q, bank_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       cc_q, cc_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       id_q, id_d;
  logic [1:0]       phase_q, phase_d;
  logic             neg_q, neg_d;
  logic [CNT_W-1:0] mlen_q, mlen_d;
  logic             closed_q, closed_d;

  logic             accept;
  logic [CNT_W-1:0] cnt_nxt;
  logic             is_digit, is_space, is_sign;
  logic [7:0]       acc_sel, acc_next, len_fin, id_fin;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_nxt    = cnt_q + CNT_W'(1);

  assign is_digit = rx_byte_i inside {[8'h30:8'h39]};
  assign is_space = (rx_byte_i == CHAR_SPACE) || (rx_byte_i inside {[8'h09:8'h0D]});
  assign is_sign  = (rx_byte_i == CHAR_MINUS) || (rx_byte_i == CHAR_PLUS);

  // acc * 10 + digit, modulo 256
  assign acc_sel  = (cc_q == 2'd0) ? len_q : id_q;
  assign acc_next = 8'((acc_sel << 3) + (acc_sel << 1) + (rx_byte_i - CHAR_ZERO));

  // Apply a pending sign to the field in progress
  assign len_fin = (cc_q == 2'd0 && neg_q) ? 8'(8'd0 - len_q) : len_q;
  assign id_fin  = (cc_q == 2'd1 && neg_q) ? 8'(8'd0 - id_q) : id_q;

  always_comb begin
    if (8'(cnt_nxt) != len_fin) begin
      desc_o.status = STAT_LEN_ERR;
    end else if (id_fin != cfg_i.function_id) begin
      desc_o.status = STAT_ID_ERR;
    end else begin
      desc_o.status = STAT_OK;
    end
    desc_o.len  = mlen_q;
    desc_o.bank = bank_q;
  end

  assign ram_waddr_o = {bank_q, mlen_q[ADDR_W-1:0]};
  assign ram_wdata_o = rx_byte_i;

  always_comb begin
    in_frame_d = in_frame_q;
    bank_d     = bank_q;
    cnt_d      = cnt_q;
    cc_d       = cc_q;
    len_d      = len_q;
    id_d       = id_q;
    phase_d    = phase_q;
    neg_d      = neg_q;
    mlen_d     = mlen_q;
    closed_d   = closed_q;
    push_o     = 1'b0;
    ram_we_o   = 1'b0;
    if (accept) begin
      if (!in_frame_q) begin
        if (rx_byte_i == cfg_i.head_byte) begin
          in_frame_d = 1'b1;
          cnt_d      = CNT_W'(1);
          cc_d       = 2'd0;
          len_d      = 8'd0;
          id_d       = 8'd0;
          phase_d    = PH_SKIP;
          neg_d      = 1'b0;
          mlen_d     = '0;
          closed_d   = 1'b0;
        end
      end else if (rx_byte_i == cfg_i.tail_byte) begin
        // Close the frame and hand it to the back end
        in_frame_d = 1'b0;
        cnt_d      = '0;
        push_o     = 1'b1;
        bank_d     = !bank_q;
      end else begin
        cnt_d = cnt_nxt;
        if (rx_byte_i == CHAR_COMMA) begin
          if (cc_q < 2'd2) begin
            len_d   = len_fin;
            id_d    = id_fin;
            phase_d = PH_SKIP;
            neg_d   = 1'b0;
          end else begin
            closed_d = 1'b1;
          end
          if (cc_q != 2'd3) begin
            cc_d = cc_q + 2'd1;
          end
        end else if (cc_q < 2'd2) begin
          if (phase_q != PH_DONE) begin
            if (is_digit) begin
              if (cc_q == 2'd0) begin
                len_d = acc_next;
              end else begin
                id_d = acc_next;
              end
              phase_d = PH_DIGIT;
            end else if (phase_q == PH_SKIP && is_space) begin
              phase_d = PH_SKIP;
            end else if (phase_q == PH_SKIP && is_sign) begin
              neg_d   = (rx_byte_i == CHAR_MINUS);
              phase_d = PH_SIGN;
            end else begin
              phase_d = PH_DONE;
            end
          end
        end else if (cc_q == 2'd2 && !closed_q && mlen_q < CNT_W'(BUF_LEN)) begin
          ram_we_o = 1'b1;
          mlen_d   = mlen_q + CNT_W'(1);
        end
        // Drop an overlong frame without a result
        if (cnt_nxt >= CNT_W'(BUF_LEN)) begin
          in_frame_d = 1'b0;
          cnt_d      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      bank_q     <= 1'b0;
      cnt_q      <= '0;
      cc_q       <= 2'd0;
      len_q      <= 8'd0;
      id_q       <= 8'd0;
      phase_q    <= PH_SKIP;
      neg_q      <= 1'b0;
      mlen_q     <= '0;
      closed_q   <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      bank_q     <= bank_d;
      cnt_q      <= cnt_d;
      cc_q       <= cc_d;
      len_q      <= len_d;
      id_q       <= id_d;
      phase_q    <= phase_d;
      neg_q      <= neg_d;
      mlen_q     <= mlen_d;
      closed_q   <= closed_d;
    end
  end

endmodule

// ===== rtl/afrp_fifo.sv =====
// Two-entry queue of finished-frame descriptors between front and back.
// Depends on afrp_pkg.
`timescale 1ns / 1ps
module afrp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  afrp_pkg::desc_t desc_i,
  input  logic            pop_i,
  output afrp_pkg::desc_t desc_o,
  output logic            full_o,
  output logic            empty_o
);
  import afrp_pkg::*;

  desc_t      entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign desc_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== rtl/afrp_back.sv =====
// Back end: drains one queued frame as a status result or message bytes.
// Depends on afrp_pkg; reads the bank RAM one byte per request.
`timescale 1ns / 1ps
module afrp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  afrp_pkg::desc_t             desc_i,
  output logic                        pop_o,
  output logic                        ram_re_o,
  output logic [afrp_pkg::RAM_AW-1:0] ram_raddr_o,
  input  logic [7:0]                  ram_rdata_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [7:0]                  msg_byte_o,
  output logic                        has_byte_o,
  output logic                        last_o
);
  import afrp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SEND = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic              valid_q, valid_d;
  status_e           status_q, status_d;
  logic [7:0]        byte_q, byte_d;
  logic              has_q, has_d;
  logic              last_q, last_d;
  logic [ADDR_W-1:0] idx_inc;

  assign idx_inc = idx_q + ADDR_W'(1);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    valid_d     = valid_q;
    status_d    = status_q;
    byte_d      = byte_q;
    has_d       = has_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = {desc_i.bank, idx_q};
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          if (desc_i.status != STAT_OK || desc_i.len == '0) begin
            // Single result: error or empty message
            valid_d  = 1'b1;
            status_d = desc_i.status;
            byte_d   = 8'd0;
            has_d    = 1'b0;
            last_d   = 1'b1;
            state_d  = S_SEND;
          end else begin
            idx_d       = '0;
            ram_re_o    = 1'b1;
            ram_raddr_o = {desc_i.bank, {ADDR_W{1'b0}}};
            state_d     = S_READ;
          end
        end
      end
      S_READ: begin
        valid_d  = 1'b1;
        status_d = STAT_OK;
        byte_d   = ram_rdata_i;
        has_d    = 1'b1;
        last_d   = (CNT_W'(idx_q) + CNT_W'(1) == desc_i.len);
        state_d  = S_SEND;
      end
      S_SEND: begin
        if (out_ready_i) begin
          valid_d = 1'b0;
          if (last_q) begin
            pop_o   = 1'b1;
            state_d = S_IDLE;
          end else begin
            idx_d       = idx_inc;
            ram_re_o    = 1'b1;
            ram_raddr_o = {desc_i.bank, idx_inc};
            state_d     = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
        valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    byte_q   <= byte_d;
    has_q    <= has_d;
    last_q   <= last_d;
  end

  assign out_valid_o = valid_q;
  assign status_o    = status_q;
  assign msg_byte_o  = byte_q;
  assign has_byte_o  = has_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/ascii_frame_receiver_parser_unit.sv =====
// Top level of the delimited ASCII command frame parser: APB registers,
// front end, descriptor queue, back end and bank RAM. Depends on afrp_pkg.
//
//   port group   dir  handshake              payload
//   in           in   in_valid_i/in_ready_o  rx_byte_i
//   out          out  out_valid_o/out_ready_i status_o msg_byte_o has_byte_o last_o
//   apb          in   psel_i/penable_i/pready_o  paddr_i pwrite_i pwdata_i prdata_o
//
// The front end takes one byte per cycle while in_ready_o is high; a frame's
// results start once the back end takes the descriptor queued at its tail byte.
// Message bytes leave through the registered RAM read: each is read in S_READ and
// held in S_SEND until taken; an error or empty-message result needs no read.
// The RAM holds two message banks; in_ready_o drops while both hold frames
// not yet delivered. Reset needs no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ascii_frame_receiver_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  msg_byte_o,
  output logic        has_byte_o,
  output logic        last_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import afrp_pkg::*;

  cfg_t              cfg_q;
  logic              cfg_we;
  logic [1:0]        reg_idx;

  logic              q_push, q_pop, q_full, q_empty;
  desc_t             push_desc, head_desc;
  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i && pready_o;
  assign reg_idx  = paddr_i[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_byte   <= HEAD_RST;
      cfg_q.tail_byte   <= TAIL_RST;
      cfg_q.function_id <= FUNC_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_HEAD: cfg_q.head_byte   <= pwdata_i[7:0];
        REG_TAIL: cfg_q.tail_byte   <= pwdata_i[7:0];
        REG_FUNC: cfg_q.function_id <= pwdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HEAD: prdata_o = {24'd0, cfg_q.head_byte};
      REG_TAIL: prdata_o = {24'd0, cfg_q.tail_byte};
      REG_FUNC: prdata_o = {24'd0, cfg_q.function_id};
      default:  prdata_o = 32'd0;
    endcase
  end

  afrp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .desc_o      (push_desc),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  afrp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (push_desc),
    .pop_i   (q_pop),
    .desc_o  (head_desc),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  afrp_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  afrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .desc_i      (head_desc),
    .pop_o       (q_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .msg_byte_o  (msg_byte_o),
    .has_byte_o  (has_byte_o),
    .last_o      (last_o)
  );

  `AFRP_ASSERT_NEVER(a_queue_no_overflow, clk_i, rst_ni, q_push && q_full, "frame pushed into full queue")
  `AFRP_ASSERT_NEVER(a_queue_no_underflow, clk_i, rst_ni, q_pop && q_empty, "pop from empty queue")
  `AFRP_ASSERT(a_error_shape, clk_i, rst_ni, (out_valid_o && status_o != STAT_OK) |-> (!has_byte_o && last_o), "error result not single")

endmodule

// ===== verif/tb_ascii_frame_receiver_parser_unit.sv =====
// Testbench for ascii_frame_receiver_parser_unit: byte stimulus, APB set-up, result checking.
// Needs afrp_pkg and the block's RTL. Results are predicted from each accepted byte.
`timescale 1ns / 1ps
module tb_ascii_frame_receiver_parser_unit;
  import afrp_pkg::*;

  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_QUOTA  = 10;

  localparam logic [1:0] REG_NONE  = 2'd3;
  localparam logic [7:0] CHAR_TAB  = 8'h09;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_NINE = CHAR_ZERO + 8'd9;

  typedef enum logic [1:0] {
    NUM_BLANK,
    NUM_SIGNED,
    NUM_DIGITS,
    NUM_DONE
  } num_phase_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       last;
  } frame_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [7:0]  msg_byte_o;
  logic        has_byte_o;
  logic        last_o;
  logic        psel_i;
  logic        penable_i;
  logic        pwrite_i;
  logic [3:0]  paddr_i;
  logic [31:0] pwdata_i;
  logic [31:0] prdata_o;
  logic        pready_o;

  ascii_frame_receiver_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .msg_byte_o  (msg_byte_o),
    .has_byte_o  (has_byte_o),
    .last_o      (last_o),
    .psel_i      (psel_i),
    .penable_i   (penable_i),
    .pwrite_i    (pwrite_i),
    .paddr_i     (paddr_i),
    .pwdata_i    (pwdata_i),
    .prdata_o    (prdata_o),
    .pready_o    (pready_o)
  );

  // Register copies and parser state of the predictor
  logic [7:0] cfg_head;
  logic [7:0] cfg_tail;
  logic [7:0] cfg_func;

  bit         pr_in_frame;
  int         pr_count;
  int         pr_commas;
  logic [7:0] pr_len;
  logic [7:0] pr_id;
  num_phase_e pr_phase;
  bit         pr_neg;
  logic [7:0] pr_msg [BUF_LEN];
  int         pr_msg_len;
  bit         pr_closed;

  frame_result_t pending_results[$];

  // Frame under construction; the length digits go in at len_pos
  logic [7:0] body_q[$];
  int         len_pos;

  int failures;
  int results_seen;
  int stuck_cycles;
  int bytes_sent;
  int burst_left;
  bit gaps_on;
  bit hold_off_req;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void begin_frame_state();
    pr_count   = 1;
    pr_commas  = 0;
    pr_len     = 8'd0;
    pr_id      = 8'd0;
    pr_phase   = NUM_BLANK;
    pr_neg     = 1'b0;
    pr_msg_len = 0;
    pr_closed  = 1'b0;
  endfunction

  function automatic void close_numeric_field();
    if (pr_neg) begin
      if (pr_commas == 0) pr_len = 8'(0 - pr_len);
      else if (pr_commas == 1) pr_id = 8'(0 - pr_id);
    end
    pr_phase = NUM_BLANK;
    pr_neg   = 1'b0;
  endfunction

  function automatic void take_numeric_char(logic [7:0] b);
    bit blank;
    blank = (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
    if (pr_phase == NUM_DONE) return;
    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      if (pr_commas == 0) pr_len = 8'(pr_len * 10 + (b - CHAR_ZERO));
      else pr_id = 8'(pr_id * 10 + (b - CHAR_ZERO));
      pr_phase = NUM_DIGITS;
    end else if (pr_phase == NUM_BLANK && blank) begin
      // keep skipping
    end else if (pr_phase == NUM_BLANK && (b == CHAR_MINUS || b == CHAR_PLUS)) begin
      pr_neg   = (b == CHAR_MINUS);
      pr_phase = NUM_SIGNED;
    end else begin
      pr_phase = NUM_DONE;
    end
  endfunction

  function automatic void queue_result(status_e st, logic [7:0] mb, logic hb, logic lst);
    pending_results.push_back('{st, mb, hb, lst});
  endfunction

  function automatic void predict_rx_byte(logic [7:0] b);
    if (!pr_in_frame) begin
      if (b == cfg_head) begin
        pr_in_frame = 1'b1;
        begin_frame_state();
      end
      return;
    end
    pr_count++;
    if (b == cfg_tail) begin
      if (pr_commas < 2) close_numeric_field();
      pr_in_frame = 1'b0;
      if (8'(pr_count) != pr_len) queue_result(STAT_LEN_ERR, 8'd0, 1'b0, 1'b1);
      else if (pr_id != cfg_func) queue_result(STAT_ID_ERR, 8'd0, 1'b0, 1'b1);
      else if (pr_msg_len == 0) queue_result(STAT_OK, 8'd0, 1'b0, 1'b1);
      else begin
        for (int i = 0; i < pr_msg_len; i++)
          queue_result(STAT_OK, pr_msg[i], 1'b1, i == pr_msg_len - 1);
      end
      pr_count = 0;
      return;
    end
    if (b == CHAR_COMMA) begin
      if (pr_commas < 2) close_numeric_field();
      else pr_closed = 1'b1;
      if (pr_commas < 3) pr_commas++;
    end else if (pr_commas < 2) begin
      take_numeric_char(b);
    end else if (pr_commas == 2 && !pr_closed && pr_msg_len < BUF_LEN) begin
      pr_msg[pr_msg_len] = b;
      pr_msg_len++;
    end
    // drop an overlong frame
    if (pr_count >= BUF_LEN) begin
      pr_in_frame = 1'b0;
      begin_frame_state();
      pr_count = 0;
    end
  endfunction

  // ----------------------------------------------------------- monitor/check

  task automatic report_mismatch(input string what, input int got, input int want);
    failures++;
    if (failures <= 40)
      $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
               results_seen);
  endtask

  always @(posedge clk_i) begin : monitor
    frame_result_t want;
    bit in_xfer;
    bit out_xfer;
    if (rst_ni) begin
      in_xfer  = in_valid_i && in_ready_o;
      out_xfer = out_valid_o && out_ready_i;
      if (in_xfer) predict_rx_byte(rx_byte_i);
      if (out_xfer) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, status", status_o, -1);
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status) report_mismatch("status", status_o, want.status);
          if (msg_byte_o !== want.msg_byte)
            report_mismatch("msg_byte", msg_byte_o, want.msg_byte);
          if (has_byte_o !== want.has_byte)
            report_mismatch("has_byte", has_byte_o, want.has_byte);
          if (last_o !== want.last) report_mismatch("last", last_o, want.last);
        end
      end
      if (in_xfer || out_xfer || psel_i) stuck_cycles = 0;
      else stuck_cycles++;
    end
  end

  initial begin
    while (stuck_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  // ----------------------------------------------------------------- receiver

  initial begin
    int mode;
    int mode_left;
    int phase_cnt;
    mode      = 0;
    mode_left = 40;
    phase_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        // hold off so both banks fill and the input stalls
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        phase_cnt++;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= (phase_cnt % 3 != 0);
        endcase
      end
    end
  end

  // ------------------------------------------------------------------- sender

  task automatic send_byte(input logic [7:0] b);
    if (burst_left <= 0) begin
      if (gaps_on && $urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic pause_sender();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endtask

  // Send head, body and, if with_tail, tail; auto_len inserts the length that makes the frame consistent
  task automatic send_frame(input bit auto_len, input bit with_tail);
    int total;
    string len_txt;
    total = body_q.size() + 3;
    if (total > 9) total++;
    len_txt = $sformatf("%0d", total);
    send_byte(cfg_head);
    for (int i = 0; i < body_q.size(); i++) begin
      if (auto_len && i == len_pos) send_text(len_txt);
      send_byte(body_q[i]);
    end
    if (auto_len && len_pos >= body_q.size()) send_text(len_txt);
    if (with_tail) send_byte(cfg_tail);
    body_q.delete();
    len_pos = 0;
  endtask

  // Close any open frame, wait for every result, then let the block go idle
  task automatic drain_block();
    pause_sender();
    if (pr_in_frame) begin
      send_byte(cfg_tail);
      pause_sender();
    end
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [7:0] val);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= {idx, 2'b00};
    pwdata_i  <= {24'($urandom()), val};
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_HEAD: cfg_head = val;
      REG_TAIL: cfg_tail = val;
      REG_FUNC: cfg_func = val;
      default: ;
    endcase
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_delimiter(logic [7:0] avoid);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == avoid || c == CHAR_COMMA || c == CHAR_SPACE || c == CHAR_PLUS ||
           c == CHAR_MINUS || (c >= CHAR_ZERO && c <= CHAR_NINE) ||
           (c >= CHAR_TAB && c <= CHAR_CR));
    return c;
  endfunction

  // ------------------------------------------------------------------- tests

  task automatic test_basic_frames();
    gaps_on = 1'b0;
    add_text(",12,HI");
    send_frame(1, 1);
    add_text(",12");
    send_frame(1, 1);
    add_text(",12,");
    send_frame(1, 1);
    // blanks, sign and a negative id; the third comma closes the message
    body_q.push_back(CHAR_TAB);
    add_text(" +0");
    len_pos = body_q.size();
    add_text(",");
    body_q.push_back(CHAR_CR);
    add_text("-244,ok,extra,,");
    send_frame(1, 1);
    drain_block();
  endtask

  task automatic test_field_errors();
    gaps_on = 1'b1;
    add_text("99,12,Q");
    send_frame(0, 1);
    add_text(",13,Q");
    send_frame(1, 1);
    add_text("1,1,Z");
    send_frame(0, 1);
    send_frame(0, 1);
    add_text("-247,12");
    send_frame(0, 1);
    add_text("266,12,A");
    send_frame(0, 1);
    add_text("x9,12,A");
    send_frame(1, 1);
    add_text(",12,$A");
    send_frame(1, 1);
    add_text(",+,Q");
    send_frame(1, 1);
    add_text("-,12,Q");
    send_frame(0, 1);
    drain_block();
  endtask

  task automatic test_overlong_and_idle();
    gaps_on = 1'b1;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cfg_tail);
    send_byte("A");
    repeat (31) body_q.push_back("a");
    send_frame(0, 0);
    // longest frame that still fits
    add_text(",12,");
    body_q.push_back(8'h00);
    body_q.push_back(8'hFF);
    body_q.push_back(8'h80);
    body_q.push_back(8'h7F);
    for (int i = 0; i < 20; i++) body_q.push_back(8'(8'h41 + i));
    send_frame(1, 1);
    add_text(",12,");
    repeat (25) body_q.push_back("z");
    send_frame(1, 1);
    drain_block();
  endtask

  task automatic test_register_extremes();
    gaps_on = 1'b1;
    apb_write(REG_NONE, 8'h55);
    add_text(",12,ok");
    send_frame(1, 1);
    drain_block();

    apb_write(REG_HEAD, 8'h00);
    apb_write(REG_TAIL, 8'hFF);
    apb_write(REG_FUNC, 8'h00);
    add_text(",0,");
    body_q.push_back(8'h00);
    body_q.push_back(8'hFE);
    send_frame(1, 1);
    add_text(",-,Q");
    send_frame(1, 1);
    add_text(",256,ab");
    send_frame(1, 1);
    drain_block();

    apb_write(REG_HEAD, 8'hFF);
    apb_write(REG_TAIL, 8'h00);
    apb_write(REG_FUNC, 8'hFF);
    add_text(",-1,x");
    send_frame(1, 1);
    add_text(",255,");
    body_q.push_back(8'hFF);
    send_frame(1, 1);
    drain_block();

    // a comma or a digit as tail still ends the frame
    apb_write(REG_HEAD, "A");
    apb_write(REG_TAIL, CHAR_COMMA);
    apb_write(REG_FUNC, 8'd7);
    send_frame(1, 1);
    drain_block();
    apb_write(REG_TAIL, CHAR_ZERO + 8'd5);
    add_text(",7");
    send_frame(1, 1);
    drain_block();
  endtask

  task automatic test_output_backpressure();
    apb_write(REG_HEAD, HEAD_RST);
    apb_write(REG_TAIL, TAIL_RST);
    apb_write(REG_FUNC, FUNC_RST);
    gaps_on      = 1'b0;
    hold_off_req = 1'b1;
    for (int k = 0; k < 3; k++) begin
      add_text($sformatf(",12,burst_%0d_data", k));
      send_frame(1, 1);
    end
    pause_sender();
    while (hold_off_req) @(posedge clk_i);
    drain_block();
  endtask

  task automatic random_frame();
    int kind;
    int n;
    int v;
    logic [7:0] c;
    string id_txt;
    kind    = $urandom_range(0, 9);
    gaps_on = ($urandom_range(0, 3) != 0);
    if (kind <= 6) begin
      case ($urandom_range(0, 3))
        1: add_text(" ");
        2: add_text("+");
        3: body_q.push_back(CHAR_TAB);
        default: ;
      endcase
      len_pos = body_q.size();
      body_q.push_back(CHAR_COMMA);
      v = cfg_func;
      case ($urandom_range(0, 5))
        0, 1: id_txt = $sformatf("%0d", v);
        2: id_txt = $sformatf("+%0d", v + 256);
        3: id_txt = $sformatf("-%0d", 256 - v);
        4: id_txt = $sformatf("  0%0d", v);
        default: id_txt = $sformatf("%0d", (v + $urandom_range(1, 255)) % 256);
      endcase
      add_text(id_txt);
      if ($urandom_range(0, 7) != 0) begin
        body_q.push_back(CHAR_COMMA);
        n = $urandom_range(0, 24 - body_q.size());
        repeat (n) begin
          if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(0, 255));
          else begin
            do c = 8'($urandom_range(0, 255));
            while (c == cfg_tail || c == CHAR_COMMA);
          end
          body_q.push_back(c);
        end
        if ($urandom_range(0, 5) == 0) add_text(",x9");
      end
      // a frame without its length field fails the length check
      send_frame(kind != 6, 1'b1);
    end else if (kind == 7) begin
      repeat ($urandom_range(0, 34)) body_q.push_back(8'($urandom_range(0, 255)));
      send_frame(0, 1'($urandom_range(0, 1)));
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat (31 + $urandom_range(0, 4)) begin
        do c = 8'($urandom_range(0, 255));
        while (c == cfg_tail);
        body_q.push_back(c);
      end
      send_frame(0, 0);
    end
  endtask

  task automatic test_random_traffic();
    int start;
    for (int p = 0; p < 4; p++) begin
      if (p == 1) begin
        apb_write(REG_HEAD, 8'($urandom_range(0, 255)));
        apb_write(REG_TAIL, 8'($urandom_range(0, 255)));
        apb_write(REG_FUNC, 8'($urandom_range(0, 255)));
      end else begin
        apb_write(REG_HEAD, pick_delimiter(8'h00));
        apb_write(REG_TAIL, pick_delimiter(cfg_head));
        apb_write(REG_FUNC, 8'($urandom_range(0, 255)));
      end
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_QUOTA) random_frame();
      drain_block();
    end
  endtask

  // -------------------------------------------------------------------- main

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    rx_byte_i   <= 8'h00;
    out_ready_i <= 1'b0;
    psel_i      <= 1'b0;
    penable_i   <= 1'b0;
    pwrite_i    <= 1'b0;
    paddr_i     <= 4'h0;
    pwdata_i    <= 32'h0;
    cfg_head     = HEAD_RST;
    cfg_tail     = TAIL_RST;
    cfg_func     = FUNC_RST;
    pr_in_frame  = 1'b0;
    begin_frame_state();
    pr_count     = 0;
    len_pos      = 0;
    failures     = 0;
    results_seen = 0;
    stuck_cycles = 0;
    bytes_sent   = 0;
    burst_left   = 0;
    gaps_on      = 1'b0;
    hold_off_req = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_frames();
    test_field_errors();
    test_overlong_and_idle();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
